@@ hdl/fa_pkg.sv @@
// Shared types, codes and field widths of the fit allocator.
package fa_pkg;

    localparam int MaxBlocksDef = 16;
    localparam int SizeW        = 16;
    localparam int IndexW       = 4;
    localparam int CountW       = 5;
    localparam int StatusW      = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN,
        ST_DONE
    } fa_state_t;

    localparam logic [StatusW-1:0] STAT_LOADED = 2'd0;
    localparam logic [StatusW-1:0] STAT_ALLOC  = 2'd1;
    localparam logic [StatusW-1:0] STAT_WAIT   = 2'd2;

    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_BEST  = 2'd1;
    localparam logic [1:0] MODE_WORST = 2'd2;

    localparam logic [1:0] REG_FIT_MODE    = 2'd0;
    localparam logic [1:0] REG_BLOCK_COUNT = 2'd1;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

endpackage

@@ hdl/fa_mem.sv @@
// Free-size table: one write port, one registered read port, per-entry valid bits.
module fa_mem #(
    parameter int DEPTH = fa_pkg::MaxBlocksDef,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    wr_en,
    input  logic [AW-1:0]           wr_addr,
    input  logic [fa_pkg::SizeW-1:0] wr_data,
    input  logic                    rd_en,
    input  logic [AW-1:0]           rd_addr,
    output logic [fa_pkg::SizeW-1:0] rd_data
);
    import fa_pkg::*;

    logic [SizeW-1:0] mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [SizeW-1:0] q_reg;
    logic             q_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            q_reg <= mem[rd_addr];
        end
    end

    // An entry never written since reset reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            q_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                q_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = q_vld_reg ? q_reg : '0;

endmodule

@@ hdl/fit_allocator_top.sv @@
// Top level of the first, best and worst fit block allocator.
//
// The block keeps a free-size table for up to MAX_BLOCKS memory blocks in a
// synchronous memory. A load transfer (tuser command 0) writes one entry at
// acceptance. An allocate transfer (tuser command 1) reads the active
// entries, 0 to min(block_count, MAX_BLOCKS)-1, one per cycle through the
// single read port, keeps the running choice of the selected policy, then
// subtracts the request from the chosen entry and writes it back. Only one
// item is in flight at a time, so the scan never meets a write to the same
// entry. The finished result sits in an output register, and the block takes
// the next item while that result still waits for m_tready. Configuration
// writes are always ready and are meant to be issued only while the block is
// idle; fit_mode 3 acts as first fit and block_count above MAX_BLOCKS is
// clamped. After reset every entry reads as zero.
module fit_allocator_top #(
    parameter int MAX_BLOCKS = fa_pkg::MaxBlocksDef
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [3:0] block_index, [19:4] request_size, rest zero
    input  logic [0:0]  s_tuser,   // [0] command
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [3:0] chosen_block, [19:4] remaining_size, rest zero
    output logic [1:0]  m_tuser    // [1:0] status
);
    import fa_pkg::*;

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    // Counter width: holds MAX_BLOCKS, the block_count register and a block index.
    localparam int NW = (CW > CountW) ? CW : CountW;

    fa_state_t          state_reg, state_next;
    logic [1:0]         fit_mode_reg;
    logic [CountW-1:0]  block_count_reg;

    logic [SizeW-1:0]   size_reg;
    logic [NW-1:0]      n_reg;
    logic [NW-1:0]      iss_reg;
    logic               iss_done_reg;
    logic               rd_v_reg;
    logic               rd_last_reg;
    logic [AW-1:0]      rd_idx_reg;
    logic               found_reg;
    logic [AW-1:0]      pick_reg;
    logic [SizeW-1:0]   pick_val_reg;

    logic [StatusW-1:0] res_status_reg;
    logic [IndexW-1:0]  res_block_reg;
    logic [SizeW-1:0]   res_size_reg;

    logic               m_tvalid_reg;
    logic [StatusW-1:0] m_status_reg;
    logic [IndexW-1:0]  m_block_reg;
    logic [SizeW-1:0]   m_size_reg;

    logic               in_cmd;
    logic [IndexW-1:0]  in_index;
    logic [SizeW-1:0]   in_size;
    logic               in_acc;
    logic [NW-1:0]      in_index_ext;
    logic               in_range;
    logic [NW-1:0]      n_act;
    logic               iss_last;
    logic               out_free;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [SizeW-1:0]   wr_data;
    logic               rd_en;
    logic [SizeW-1:0]   rd_data;
    logic               fits;
    logic [NW-1:0]      pick_ext;

    assign in_cmd   = s_tuser[0];
    assign in_index = s_tdata[3:0];
    assign in_size  = s_tdata[19:4];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;

    assign in_index_ext = NW'(in_index);
    assign in_range     = in_index_ext < NW'(MAX_BLOCKS);
    assign n_act        = (NW'(block_count_reg) > NW'(MAX_BLOCKS)) ? NW'(MAX_BLOCKS)
                                                                  : NW'(block_count_reg);
    assign iss_last     = (iss_reg == n_reg - NW'(1));
    assign out_free     = !m_tvalid_reg || m_tready;
    assign pick_ext     = NW'(pick_reg);

    // Memory port usage: loads write at acceptance, an allocate writes back
    // the chosen entry in the finish state, and the scan owns the read port.
    assign rd_en   = (state_reg == ST_SCAN) && !iss_done_reg;
    assign wr_en   = (in_acc && (in_cmd == CMD_LOAD) && in_range)
                  || ((state_reg == ST_FIN) && found_reg);
    assign wr_addr = (state_reg == ST_FIN) ? pick_reg : in_index_ext[AW-1:0];
    assign wr_data = (state_reg == ST_FIN) ? (pick_val_reg - size_reg) : in_size;

    fa_mem #(
        .DEPTH (MAX_BLOCKS),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (iss_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign fits = (rd_data >= size_reg);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_mode_reg    <= MODE_FIRST;
            block_count_reg <= CountW'(16);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_FIT_MODE:    fit_mode_reg    <= cfg_data[1:0];
                REG_BLOCK_COUNT: block_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if ((in_cmd == CMD_LOAD) || (n_act == '0)) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (rd_v_reg && rd_last_reg) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            iss_done_reg <= 1'b0;
            rd_v_reg     <= 1'b0;
            rd_last_reg  <= 1'b0;
            found_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_v_reg    <= rd_en;
            rd_last_reg <= rd_en && iss_last;
            if (in_acc) begin
                iss_done_reg <= (n_act == '0);
                found_reg    <= 1'b0;
            end else if (rd_en && iss_last) begin
                iss_done_reg <= 1'b1;
            end
            if (rd_v_reg && fits && !found_reg) begin
                found_reg <= 1'b1;
            end
        end
    end

    // Scan datapath and result staging.
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            size_reg <= in_size;
            n_reg    <= n_act;
            iss_reg  <= '0;
            if (in_cmd == CMD_LOAD) begin
                res_status_reg <= STAT_LOADED;
                res_block_reg  <= in_index;
                res_size_reg   <= in_range ? in_size : '0;
            end else begin
                res_status_reg <= STAT_WAIT;
                res_block_reg  <= '0;
                res_size_reg   <= '0;
            end
        end
        if (rd_en) begin
            iss_reg    <= iss_reg + NW'(1);
            rd_idx_reg <= iss_reg[AW-1:0];
        end
        // Running choice; ties keep the earlier, lower index.
        if (rd_v_reg && fits) begin
            priority if (!found_reg) begin
                pick_reg     <= rd_idx_reg;
                pick_val_reg <= rd_data;
            end else if ((fit_mode_reg == MODE_BEST) && (rd_data < pick_val_reg)) begin
                pick_reg     <= rd_idx_reg;
                pick_val_reg <= rd_data;
            end else if ((fit_mode_reg == MODE_WORST) && (rd_data > pick_val_reg)) begin
                pick_reg     <= rd_idx_reg;
                pick_val_reg <= rd_data;
            end
        end
        if (state_reg == ST_FIN) begin
            if (found_reg) begin
                res_status_reg <= STAT_ALLOC;
                res_block_reg  <= pick_ext[IndexW-1:0];
                res_size_reg   <= pick_val_reg - size_reg;
            end else begin
                res_status_reg <= STAT_WAIT;
                res_block_reg  <= '0;
                res_size_reg   <= '0;
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if ((state_reg == ST_DONE) && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_DONE) && out_free) begin
            m_status_reg <= res_status_reg;
            m_block_reg  <= res_block_reg;
            m_size_reg   <= res_size_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {4'b0000, m_size_reg, m_block_reg};

`ifndef ASSERT_OFF
    // Read data only comes back while a scan is running.
    a_read_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_v_reg |-> (state_reg == ST_SCAN))
        else $error("read data returned outside a scan");

    // The chosen entry always covers the request, so the write-back never wraps.
    a_pick_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_FIN) && found_reg) |-> (pick_val_reg >= size_reg))
        else $error("chosen block is smaller than the request");

    // A waiting result carries no block and no size.
    a_wait_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == STAT_WAIT)) |-> (m_tdata == '0))
        else $error("waiting result carries a nonzero payload");
`endif

endmodule

@@ sim/tb.sv @@
// Self-checking testbench of the fit allocator: free-size table predictor, scoreboard and drivers.
`timescale 1ns / 100ps

module tb;
    import fa_pkg::*;

    localparam int TableDepth  = MaxBlocksDef;
    localparam int RandomItems = 1400;
    // Cycles without any transfer before the run is declared hung. The slowest
    // legal stretch is one allocate scan plus the longest sender gap and the
    // longest receiver stall.
    localparam int StallLimit  = 2000;
    // Unused policy code; the block treats it as first fit.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // One result as the block reports it.
    typedef struct packed {
        logic [StatusW-1:0] status;
        logic [IndexW-1:0]  block;
        logic [SizeW-1:0]   remaining;
    } fit_result_t;

    // The scoreboard keeps its own copy of the free-size table and of the two
    // registers. Each accepted input transfer is run through the placement
    // policy at once, and the outcome waits in a queue until the matching
    // result transfer shows up.
    class fit_scoreboard;
        logic [SizeW-1:0]  block_free [TableDepth];
        logic [1:0]        fit_mode;
        logic [CountW-1:0] block_count;
        fit_result_t       awaited_results [$];
        int unsigned       mismatches;

        function new();
            foreach (block_free[i]) block_free[i] = '0;
            fit_mode    = MODE_FIRST;
            block_count = CountW'(TableDepth);
            mismatches  = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [CountW-1:0] value);
            if (idx == REG_FIT_MODE) begin
                fit_mode = value[1:0];
            end else if (idx == REG_BLOCK_COUNT) begin
                block_count = value;
            end
        endfunction

        function void predict_placement(logic cmd, logic [IndexW-1:0] idx,
                                        logic [SizeW-1:0] size);
            fit_result_t res;
            int          active;
            int          pick;
            int          j;
            bit          found;
            if (cmd == CMD_LOAD) begin
                res.status = STAT_LOADED;
                res.block  = idx;
                if (int'(idx) < TableDepth) begin
                    block_free[idx] = size;
                    res.remaining   = size;
                end else begin
                    res.remaining = '0;
                end
            end else begin
                active = (int'(block_count) > TableDepth) ? TableDepth : int'(block_count);
                found  = 1'b0;
                pick   = 0;
                for (j = 0; j < active; j++) begin
                    if (block_free[j] >= size) begin
                        if (!found) begin
                            pick  = j;
                            found = 1'b1;
                            // First fit and the spare code stop at the first hit.
                            if (fit_mode != MODE_BEST && fit_mode != MODE_WORST) break;
                        end else if (fit_mode == MODE_BEST && block_free[j] < block_free[pick]) begin
                            pick = j;
                        end else if (fit_mode == MODE_WORST && block_free[j] > block_free[pick]) begin
                            pick = j;
                        end
                    end
                end
                if (found) begin
                    block_free[pick] = block_free[pick] - size;
                    res.status    = STAT_ALLOC;
                    res.block     = IndexW'(pick);
                    res.remaining = block_free[pick];
                end else begin
                    res.status    = STAT_WAIT;
                    res.block     = '0;
                    res.remaining = '0;
                end
            end
            awaited_results.push_back(res);
        endfunction

        function void compare_result(logic [StatusW-1:0] status, logic [IndexW-1:0] block,
                                     logic [SizeW-1:0] remaining);
            fit_result_t want;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d block %0d remaining %0d",
                             status, block, remaining);
                return;
            end
            want = awaited_results.pop_front();
            if (status !== want.status || block !== want.block
                    || remaining !== want.remaining) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected status %0d block %0d remaining %0d, got status %0d block %0d remaining %0d",
                             want.status, want.block, want.remaining,
                             status, block, remaining);
            end
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [1:0]        cfg_index;
    logic [4:0]        cfg_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [23:0]       s_tdata;   // [3:0] block_index, [19:4] request_size, rest zero
    logic [0:0]        s_tuser;   // [0] command
    logic              m_tvalid;
    logic              m_tready;
    logic [23:0]       m_tdata;   // [3:0] chosen_block, [19:4] remaining_size, rest zero
    logic [1:0]        m_tuser;   // [1:0] status

    fit_scoreboard sb = new();

    // When set, neither side inserts idle cycles, so the block sees
    // back-to-back transfers for a whole phase.
    bit          calm_phase;
    int unsigned idle_cycles;
    int unsigned random_sent;

    fit_allocator_top #(
        .MAX_BLOCKS (TableDepth)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Drives one input transfer. Inputs move only at the falling edge, and the
    // handshake is judged from the values seen at the rising edge. On return
    // tvalid is still high; the next call either replaces the data or drops
    // tvalid at the following falling edge, before the block can sample again.
    task automatic send_item(input logic cmd, input logic [IndexW-1:0] idx,
                             input logic [SizeW-1:0] size);
        int gap;
        gap = calm_phase ? 0 : $urandom_range(0, 7);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {4'b0000, size, idx};
        s_tuser  = cmd;
        do @(posedge aclk); while (!s_tready);
        sb.predict_placement(cmd, idx, size);
    endtask

    // Stops the input stream and waits until every predicted result has been
    // received, so that the block is idle, plus a few cycles of margin.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.awaited_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [CountW-1:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_register(idx, value);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Registers are only touched while nothing is in flight.
    task automatic set_phase(input logic [1:0] mode, input logic [CountW-1:0] count);
        drain_results();
        write_register(REG_FIT_MODE, {3'b000, mode});
        write_register(REG_BLOCK_COUNT, count);
    endtask

    // Random content with a bias toward sizes that actually fit, so that most
    // allocates land and keep the table moving; full-range values, zero and
    // the maximum size still show up regularly.
    task automatic random_item();
        logic             cmd;
        logic [SizeW-1:0] size;
        cmd = ($urandom_range(0, 9) < 4) ? CMD_LOAD : CMD_ALLOC;
        if (cmd == CMD_LOAD) begin
            case ($urandom_range(0, 9))
                0:       size = '0;
                1:       size = '1;
                2, 3, 4: size = SizeW'($urandom_range(0, 1023));
                default: size = SizeW'($urandom);
            endcase
        end else begin
            case ($urandom_range(0, 9))
                0:          size = '0;
                1:          size = '1;
                2, 3, 4, 5: size = SizeW'($urandom_range(0, 255));
                6, 7:       size = SizeW'($urandom_range(0, 4095));
                default:    size = SizeW'($urandom);
            endcase
        end
        send_item(cmd, IndexW'($urandom_range(0, 15)), size);
    endtask

    // The result side draws a fresh stall before every transfer. The ready
    // line is written once per falling edge at most.
    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            stall = calm_phase ? 0 : $urandom_range(0, 7);
            repeat (stall) begin
                @(negedge aclk);
                m_tready = 1'b0;
            end
            @(negedge aclk);
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.compare_result(m_tuser, m_tdata[IndexW-1:0], m_tdata[IndexW+SizeW-1:IndexW]);
        end
    end

    // Any transfer on any channel counts as progress. A long stretch without
    // one means the block has hung.
    initial begin : watchdog
        idle_cycles = 0;
        wait (aresetn);
        while (idle_cycles < StallLimit) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        int          phase_len;
        int          pause_at;
        int          k;
        logic [1:0]  mode;
        logic [CountW-1:0] count;
        aresetn    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        calm_phase = 1'b0;
        random_sent = 0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // Directed part. First fit over the full table: a zero request fits a
        // block whose free size is zero, the maximum size drains the top block,
        // and a second maximum request finds no room and waits.
        set_phase(MODE_FIRST, CountW'(TableDepth));
        send_item(CMD_LOAD, 4'd0, 16'd0);
        send_item(CMD_LOAD, 4'd1, 16'd100);
        send_item(CMD_LOAD, 4'd2, 16'd50);
        send_item(CMD_LOAD, 4'd3, 16'd200);
        send_item(CMD_LOAD, 4'd15, 16'hFFFF);
        send_item(CMD_ALLOC, 4'd9, 16'd0);
        send_item(CMD_ALLOC, 4'd15, 16'd60);
        send_item(CMD_ALLOC, 4'd0, 16'hFFFF);
        send_item(CMD_ALLOC, 4'd7, 16'hFFFF);

        // Best fit picks the tightest block that fits.
        set_phase(MODE_BEST, CountW'(TableDepth));
        send_item(CMD_ALLOC, 4'd0, 16'd45);
        send_item(CMD_ALLOC, 4'd0, 16'd30);

        // Worst fit, including a tie between two equal blocks that the lower
        // index must win.
        set_phase(MODE_WORST, CountW'(TableDepth));
        send_item(CMD_ALLOC, 4'd0, 16'd10);
        send_item(CMD_LOAD, 4'd4, 16'd190);
        send_item(CMD_ALLOC, 4'd0, 16'd1);

        // The spare policy code behaves as first fit.
        set_phase(MODE_SPARE, CountW'(TableDepth));
        send_item(CMD_ALLOC, 4'd0, 16'd5);

        // With no active blocks every allocate waits; a load still lands in
        // the table even though it is outside the searched range.
        set_phase(MODE_SPARE, 5'd0);
        send_item(CMD_ALLOC, 4'd0, 16'd0);
        send_item(CMD_LOAD, 4'd9, 16'd500);

        // Block nine stays invisible at a count of two, then an oversized
        // count is clamped to the full table and reaches it.
        set_phase(MODE_FIRST, 5'd2);
        send_item(CMD_ALLOC, 4'd0, 16'd400);
        set_phase(MODE_FIRST, 5'd31);
        send_item(CMD_ALLOC, 4'd0, 16'd400);

        // Random phases, each with its own policy, block count and idling
        // pattern. Some phases hold the sender mid-way until every result is
        // back.
        while (random_sent < RandomItems) begin
            mode = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 7))
                0:       count = '0;
                1:       count = CountW'(1);
                2:       count = CountW'(2);
                3:       count = CountW'(TableDepth);
                4:       count = CountW'($urandom_range(17, 31));
                default: count = CountW'($urandom_range(1, 16));
            endcase
            set_phase(mode, count);
            calm_phase = ($urandom_range(0, 3) == 0);
            phase_len  = $urandom_range(40, 100);
            pause_at   = $urandom_range(1, 2 * phase_len);
            for (k = 0; k < phase_len; k++) begin
                if (k == pause_at) drain_results();
                random_item();
                random_sent++;
            end
        end

        drain_results();
        repeat (30) @(posedge aclk);
        if (sb.mismatches == 0 && sb.awaited_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
